>>> hdl/bsf_pkg.sv
// ----------------------------------------------------------------------------
// bsf_pkg
// Shared types and constants of the IPv4 source blacklist filter.
// ----------------------------------------------------------------------------
package bsf_pkg;

    // Blacklist size and index width
    localparam int BLACKLIST_DEPTH = 16;
    localparam int BL_IDX_W        = (BLACKLIST_DEPTH > 1) ? $clog2(BLACKLIST_DEPTH) : 1;

    // Request codes
    localparam logic [1:0] REQ_PACKET = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;

    // Verdict causes
    localparam logic [1:0] CAUSE_PASS      = 2'd0;
    localparam logic [1:0] CAUSE_NOT_IPV4  = 2'd1;
    localparam logic [1:0] CAUSE_BLACKLIST = 2'd2;
    localparam logic [1:0] CAUSE_SIGNATURE = 2'd3;

    // Table request status
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // Protocol constants
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
    localparam logic [31:0] SIG_WORD       = {8'h41, 8'h49, 8'h4E, 8'h43}; // "AINC"

    // Byte offsets within the frame (IP header fixed at 20 bytes)
    localparam logic [5:0] OFF_ETYPE_HI = 6'd12;
    localparam logic [5:0] OFF_ETYPE_LO = 6'd13;
    localparam logic [5:0] OFF_PROTO    = 6'd23;
    localparam logic [5:0] OFF_SRC_LO   = 6'd26;
    localparam logic [5:0] OFF_SRC_HI   = 6'd29;
    localparam logic [5:0] OFF_PAY_LO   = 6'd42;
    localparam logic [5:0] OFF_PAY_HI   = 6'd45;
    localparam logic [5:0] OFF_MAX      = 6'd63;

    // Minimum lengths
    localparam logic [5:0] LEN_ETH = 6'd14;
    localparam logic [5:0] LEN_IPV4 = 6'd34;
    localparam logic [5:0] LEN_SIG = 6'd46;

    // Header fields of the frame, including the byte now being taken
    typedef struct packed {
        logic [5:0]  len;
        logic [15:0] ether_type;
        logic [7:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] payload_head;
    } t_frame_info;

    // Blacklist command and response
    typedef struct packed {
        logic insert;
        logic remove;
    } t_tbl_cmd;

    typedef struct packed {
        logic hit;
        logic has_free;
    } t_tbl_rsp;

endpackage

>>> hdl/bsf_parser.sv
// ----------------------------------------------------------------------------
// bsf_parser
// Frame byte counter and header field capture; clears at frame end.
// ----------------------------------------------------------------------------
module bsf_parser
    import bsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_byte_en,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    output t_frame_info o_frame
);

    logic [5:0]  r_offset;
    logic [15:0] r_ether_type;
    logic [7:0]  r_protocol;
    logic [31:0] r_src_addr;
    logic [31:0] r_payload_head;

    t_frame_info n_frame;

    // Fold the current byte into the header fields
    always_comb begin
        n_frame.len          = (r_offset == OFF_MAX) ? r_offset : r_offset + 6'd1;
        n_frame.ether_type   = r_ether_type;
        n_frame.protocol     = r_protocol;
        n_frame.src_addr     = r_src_addr;
        n_frame.payload_head = r_payload_head;
        if (r_offset == OFF_ETYPE_HI || r_offset == OFF_ETYPE_LO) begin
            n_frame.ether_type = {r_ether_type[7:0], i_byte};
        end else if (r_offset == OFF_PROTO) begin
            n_frame.protocol = i_byte;
        end else if (r_offset >= OFF_SRC_LO && r_offset <= OFF_SRC_HI) begin
            n_frame.src_addr = {r_src_addr[23:0], i_byte};
        end else if (r_offset >= OFF_PAY_LO && r_offset <= OFF_PAY_HI) begin
            n_frame.payload_head = {r_payload_head[23:0], i_byte};
        end
    end

    assign o_frame = n_frame;

    // Frame state: advance on each byte, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_byte_en && i_last)) begin
            r_offset       <= '0;
            r_ether_type   <= '0;
            r_protocol     <= '0;
            r_src_addr     <= '0;
            r_payload_head <= '0;
        end else if (i_byte_en) begin
            r_offset       <= n_frame.len;
            r_ether_type   <= n_frame.ether_type;
            r_protocol     <= n_frame.protocol;
            r_src_addr     <= n_frame.src_addr;
            r_payload_head <= n_frame.payload_head;
        end
    end

endmodule

>>> hdl/bsf_table.sv
// ----------------------------------------------------------------------------
// bsf_table
// Blacklist of IPv4 source addresses: parallel match, insert, remove.
// ----------------------------------------------------------------------------
module bsf_table
    import bsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_tbl_cmd    i_cmd,
    input  logic [31:0] i_addr,
    output t_tbl_rsp    o_rsp
);

    logic [31:0]                r_entry [BLACKLIST_DEPTH];
    logic [BLACKLIST_DEPTH-1:0] r_valid;
    logic [BLACKLIST_DEPTH-1:0] n_valid;
    logic [BLACKLIST_DEPTH-1:0] match;
    logic [BL_IDX_W-1:0]        free_idx;
    logic                       has_free;

    // Compare every valid entry against the lookup address
    always_comb begin
        for (int i = 0; i < BLACKLIST_DEPTH; i++) begin
            match[i] = r_valid[i] && (r_entry[i] == i_addr);
        end
    end

    // Lowest free slot
    always_comb begin
        free_idx = '0;
        has_free = 1'b0;
        for (int i = BLACKLIST_DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = BL_IDX_W'(i);
                has_free = 1'b1;
            end
        end
    end

    assign o_rsp.hit      = |match;
    assign o_rsp.has_free = has_free;

    // Valid marks: set on insert of an absent address, clear on remove
    always_comb begin
        n_valid = r_valid;
        if (i_cmd.insert && !o_rsp.hit && has_free) begin
            n_valid[free_idx] = 1'b1;
        end else if (i_cmd.remove) begin
            n_valid = r_valid & ~match;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Address store, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && !o_rsp.hit && has_free) begin
            r_entry[free_idx] <= i_addr;
        end
    end

endmodule

>>> hdl/ipv4_blacklist_signature_filter.sv
// ----------------------------------------------------------------------------
// ipv4_blacklist_signature_filter
// Per-frame IPv4 source blacklist and UDP payload signature filter.
// ----------------------------------------------------------------------------
// Takes one word per clock: a frame byte (with a last-byte mark) or a
// blacklist insert/remove request. Every word passes through an input
// register and combinational logic into an output register; one word per
// clock is sustained while the output side is ready. While a finished
// result waits, bytes that give no result keep moving; the input stalls
// once a word with a result sits in the input register. The 16-entry
// blacklist is matched in parallel by the logic between the two registers.
// Each final frame byte gives one verdict, each table request one
// acknowledgement; other bytes give no result. The blacklist starts empty
// after reset, with no clearing pass.
module ipv4_blacklist_signature_filter
    import bsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_packet_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_table_address,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_table_ack,
    output logic        o_verdict,
    output logic [1:0]  o_cause,
    output logic [1:0]  o_table_status,
    output logic [31:0] o_ipv4_packets
);

    // Input register
    logic        r_s1_valid;
    logic [1:0]  r_s1_req;
    logic [7:0]  r_s1_byte;
    logic        r_s1_last;
    logic [31:0] r_s1_addr;

    // Output register
    logic        r_out_valid;
    logic        r_ack;
    logic        r_verdict;
    logic [1:0]  r_cause;
    logic [1:0]  r_status;
    logic [31:0] r_count_out;

    logic [31:0] r_count;
    logic [31:0] n_count;

    logic        is_pkt;
    logic        is_ins;
    logic        is_rem;
    logic        has_result;
    logic        advance;
    logic        frame_end;
    logic        not_ipv4;
    logic        sig_hit;
    logic        n_verdict;
    logic [1:0]  n_cause;
    logic [1:0]  n_status;
    logic [31:0] lookup_addr;

    t_frame_info frame;
    t_tbl_cmd    tbl_cmd;
    t_tbl_rsp    tbl_rsp;

    // Request decode
    assign is_pkt     = (r_s1_req == REQ_PACKET);
    assign is_ins     = (r_s1_req == REQ_INSERT);
    assign is_rem     = (r_s1_req == REQ_REMOVE);
    assign has_result = is_ins || is_rem || (is_pkt && r_s1_last);

    // Word in the input register leaves when its result has a place
    assign advance    = r_s1_valid && (!has_result || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_req  <= i_req_type;
            r_s1_byte <= i_packet_byte;
            r_s1_last <= i_last_byte;
            r_s1_addr <= i_table_address;
        end
    end

    bsf_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (advance && is_pkt),
        .i_byte    (r_s1_byte),
        .i_last    (r_s1_last),
        .o_frame   (frame)
    );

    // One match port: frame source address or request address
    assign lookup_addr    = is_pkt ? frame.src_addr : r_s1_addr;
    assign tbl_cmd.insert = advance && is_ins;
    assign tbl_cmd.remove = advance && is_rem;

    bsf_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (tbl_cmd),
        .i_addr  (lookup_addr),
        .o_rsp   (tbl_rsp)
    );

    // Frame checks
    assign not_ipv4 = (frame.len < LEN_ETH) || (frame.ether_type != ETHERTYPE_IPV4) ||
                      (frame.len < LEN_IPV4);
    assign sig_hit  = (frame.protocol == IP_PROTO_UDP) && (frame.len >= LEN_SIG) &&
                      (frame.payload_head == SIG_WORD);
    assign frame_end = advance && is_pkt && r_s1_last;

    always_comb begin
        n_verdict = 1'b0;
        n_cause   = CAUSE_PASS;
        n_status  = STATUS_OK;
        if (is_pkt) begin
            if (not_ipv4) begin
                n_cause = CAUSE_NOT_IPV4;
            end else if (tbl_rsp.hit) begin
                n_verdict = 1'b1;
                n_cause   = CAUSE_BLACKLIST;
            end else if (sig_hit) begin
                n_verdict = 1'b1;
                n_cause   = CAUSE_SIGNATURE;
            end
        end else if (is_ins) begin
            if (!tbl_rsp.hit && !tbl_rsp.has_free) begin
                n_status = STATUS_FULL;
            end
        end else if (!tbl_rsp.hit) begin
            n_status = STATUS_NOT_FOUND;
        end
    end

    // IPv4 frame counter, wraps
    assign n_count = (frame_end && !not_ipv4) ? r_count + 32'd1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && has_result) begin
            r_ack       <= !is_pkt;
            r_verdict   <= n_verdict;
            r_cause     <= n_cause;
            r_status    <= n_status;
            r_count_out <= n_count;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_is_table_ack = r_ack;
    assign o_verdict      = r_verdict;
    assign o_cause        = r_cause;
    assign o_table_status = r_status;
    assign o_ipv4_packets = r_count_out;

`ifndef SYNTHESIS
    // Verdicts carry no table status
    a_verdict_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_ack) |-> (r_status == STATUS_OK))
        else $error("verdict with table status");

    // Acknowledgements carry no verdict or cause
    a_ack_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ack) |-> (!r_verdict && (r_cause == CAUSE_PASS)))
        else $error("acknowledgement with verdict fields");

    // Drop exactly for blacklist or signature causes
    a_drop_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_verdict == ((r_cause == CAUSE_BLACKLIST) ||
                                       (r_cause == CAUSE_SIGNATURE))))
        else $error("verdict and cause disagree");

    // Counter moves only at a frame end
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !frame_end |=> (r_count == $past(r_count)))
        else $error("counter changed without a frame end");
`endif

endmodule

>>> bench/ipv4_blacklist_signature_filter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ipv4_blacklist_signature_filter_test
// Self-checking bench for the IPv4 source blacklist and payload signature
// filter. Frames and blacklist requests are driven word by word; a shadow
// model of the parser and the blacklist predicts each verdict and each
// acknowledgement, which are checked field by field in order.
// ----------------------------------------------------------------------------
import bsf_pkg::*;

typedef struct packed {
    logic        is_table_ack;
    logic        verdict;
    logic [1:0]  cause;
    logic [1:0]  table_status;
    logic [31:0] ipv4_packets;
} t_filter_result;

// Shadow copy of the frame parser and the blacklist, plus pending results
class verdict_scoreboard;
    t_filter_result expected_results[$];
    int unsigned    mismatches;

    logic [5:0]  frame_len;
    logic [15:0] frame_etype;
    logic [7:0]  frame_proto;
    logic [31:0] frame_src;
    logic [31:0] frame_head;
    logic [31:0] packet_count;
    logic [31:0] blocked[BLACKLIST_DEPTH];
    bit          in_use[BLACKLIST_DEPTH];

    function new();
        mismatches   = 0;
        packet_count = '0;
        clear_frame();
        for (int i = 0; i < BLACKLIST_DEPTH; i++) begin
            blocked[i] = '0;
            in_use[i]  = 1'b0;
        end
    endfunction

    function void clear_frame();
        frame_len   = '0;
        frame_etype = '0;
        frame_proto = '0;
        frame_src   = '0;
        frame_head  = '0;
    endfunction

    // Index of a valid entry holding addr, or -1
    function int find_blocked(logic [31:0] addr);
        int hit;
        hit = -1;
        for (int i = 0; i < BLACKLIST_DEPTH; i++)
            if (hit < 0 && in_use[i] && blocked[i] == addr)
                hit = i;
        return hit;
    endfunction

    // Accepted input word: update the shadow state, queue any result
    function void note_word(logic [1:0] req, logic [7:0] data, logic last,
                            logic [31:0] addr);
        t_filter_result res;
        int slot;
        res = '0;
        case (req)
            REQ_INSERT: begin
                res.is_table_ack = 1'b1;
                res.table_status = STATUS_OK;
                if (find_blocked(addr) < 0) begin
                    slot = -1;
                    for (int i = 0; i < BLACKLIST_DEPTH; i++)
                        if (slot < 0 && !in_use[i])
                            slot = i;
                    if (slot < 0) begin
                        res.table_status = STATUS_FULL;
                    end else begin
                        in_use[slot]  = 1'b1;
                        blocked[slot] = addr;
                    end
                end
                res.ipv4_packets = packet_count;
                expected_results.push_back(res);
            end
            REQ_REMOVE: begin
                res.is_table_ack = 1'b1;
                slot = find_blocked(addr);
                if (slot < 0) begin
                    res.table_status = STATUS_NOT_FOUND;
                end else begin
                    in_use[slot]     = 1'b0;
                    res.table_status = STATUS_OK;
                end
                res.ipv4_packets = packet_count;
                expected_results.push_back(res);
            end
            REQ_PACKET: begin
                // capture header bytes by position (IP header fixed at 20 bytes)
                if (frame_len == OFF_ETYPE_HI || frame_len == OFF_ETYPE_LO)
                    frame_etype = {frame_etype[7:0], data};
                else if (frame_len == OFF_PROTO)
                    frame_proto = data;
                else if (frame_len >= OFF_SRC_LO && frame_len <= OFF_SRC_HI)
                    frame_src = {frame_src[23:0], data};
                else if (frame_len >= OFF_PAY_LO && frame_len <= OFF_PAY_HI)
                    frame_head = {frame_head[23:0], data};
                if (frame_len != OFF_MAX)
                    frame_len = frame_len + 6'd1;

                if (last) begin
                    res.is_table_ack = 1'b0;
                    res.table_status = STATUS_OK;
                    if (frame_len < LEN_ETH || frame_etype != ETHERTYPE_IPV4 ||
                        frame_len < LEN_IPV4) begin
                        res.verdict = 1'b0;
                        res.cause   = CAUSE_NOT_IPV4;
                    end else begin
                        packet_count = packet_count + 32'd1;
                        if (find_blocked(frame_src) >= 0) begin
                            res.verdict = 1'b1;
                            res.cause   = CAUSE_BLACKLIST;
                        end else if (frame_proto == IP_PROTO_UDP && frame_len >= LEN_SIG &&
                                     frame_head == SIG_WORD) begin
                            res.verdict = 1'b1;
                            res.cause   = CAUSE_SIGNATURE;
                        end else begin
                            res.verdict = 1'b0;
                            res.cause   = CAUSE_PASS;
                        end
                    end
                    res.ipv4_packets = packet_count;
                    expected_results.push_back(res);
                    clear_frame();
                end
            end
            default: ;  // unused request code: ignored
        endcase
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Accepted output word: compare with the oldest prediction
    function void check_result(logic ack, logic drop, logic [1:0] cause,
                               logic [1:0] status, logic [31:0] packets);
        t_filter_result want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: ack=%0d verdict=%0d cause=%0d status=%0d",
                   ack, drop, cause, status);
            mismatches++;
        end else begin
            want = expected_results.pop_front();
            compare_field("is_table_ack", 32'(want.is_table_ack), 32'(ack));
            compare_field("verdict", 32'(want.verdict), 32'(drop));
            compare_field("cause", 32'(want.cause), 32'(cause));
            compare_field("table_status", 32'(want.table_status), 32'(status));
            compare_field("ipv4_packets", want.ipv4_packets, packets);
        end
    endfunction
endclass

module ipv4_blacklist_signature_filter_test;

    localparam int         IDLE_LIMIT   = 4000;
    localparam int         RANDOM_WORDS = 1250;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         POOL_SIZE    = 20;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam logic [7:0] PROTO_TCP    = 8'd6;
    localparam logic [15:0] ETHERTYPE_IPV6 = 16'h86DD;

    typedef enum {RX_ALWAYS, RX_COIN, RX_QUARTER, RX_MOSTLY} t_rx_mode;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [1:0]  i_req_type      = REQ_PACKET;
    logic [7:0]  i_packet_byte   = '0;
    logic        i_last_byte     = 1'b0;
    logic [31:0] i_table_address = '0;
    logic        i_out_ready     = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_is_table_ack;
    logic        o_verdict;
    logic [1:0]  o_cause;
    logic [1:0]  o_table_status;
    logic [31:0] o_ipv4_packets;

    verdict_scoreboard board;

    int       burst_left   = 0;
    int       words_sent   = 0;
    int       idle_cycles  = 0;
    int       rx_cycle     = 0;
    int       hold_left    = 0;
    bit       hold_request = 1'b0;
    t_rx_mode rx_mode      = RX_ALWAYS;
    logic [31:0] addr_pool[POOL_SIZE];

    ipv4_blacklist_signature_filter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_packet_byte   (i_packet_byte),
        .i_last_byte     (i_last_byte),
        .i_table_address (i_table_address),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_is_table_ack  (o_is_table_ack),
        .o_verdict       (o_verdict),
        .o_cause         (o_cause),
        .o_table_status  (o_table_status),
        .o_ipv4_packets  (o_ipv4_packets)
    );

    always #5 i_clk = ~i_clk;

    // Output side: check accepted words, then pick next ready value
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_is_table_ack, o_verdict, o_cause, o_table_status,
                               o_ipv4_packets);
        rx_cycle++;
        if (hold_request && hold_left == 0) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_cycle % 256 == 0)
                rx_mode = t_rx_mode'($urandom_range(0, 3));
            case (rx_mode)
                RX_ALWAYS:  i_out_ready <= 1'b1;
                RX_COIN:    i_out_ready <= 1'($urandom_range(0, 1));
                RX_QUARTER: i_out_ready <= (rx_cycle % 4 == 0);
                default:    i_out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog: cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("ipv4_blacklist_signature_filter_test: errors");
            $finish;
        end
    end

    // One word through the input handshake, with bursty gaps
    task automatic send_word(logic [1:0] req, logic [7:0] data, logic last,
                             logic [31:0] addr);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_packet_byte   <= data;
        i_last_byte     <= last;
        i_table_address <= addr;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_word(req, data, last, addr);
        if (req != REQ_UNUSED)
            words_sent++;
    endtask

    task automatic send_table(logic [1:0] req, logic [31:0] addr);
        send_word(req, 8'($urandom), 1'($urandom_range(0, 1)), addr);
    endtask

    function automatic logic [31:0] pick_addr();
        return ($urandom_range(0, 4) != 0) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                           : $urandom;
    endfunction

    // Frame with the given header fields; filler bytes are random
    task automatic send_frame(int len, logic [15:0] etype, logic [7:0] proto,
                              logic [31:0] src, logic [31:0] head, bit with_request);
        int         cut;
        logic [7:0] data;
        cut = with_request ? $urandom_range(0, len - 1) : -1;
        for (int i = 0; i < len; i++) begin
            if (i == cut)
                send_table($urandom_range(0, 1) ? REQ_INSERT : REQ_REMOVE, pick_addr());
            case (i)
                12:      data = etype[15:8];
                13:      data = etype[7:0];
                23:      data = proto;
                26:      data = src[31:24];
                27:      data = src[23:16];
                28:      data = src[15:8];
                29:      data = src[7:0];
                42:      data = head[31:24];
                43:      data = head[23:16];
                44:      data = head[15:8];
                45:      data = head[7:0];
                default: data = 8'($urandom);
            endcase
            send_word(REQ_PACKET, data, (i == len - 1), $urandom);
        end
    endtask

    task automatic random_frame(bit well_formed);
        int          len;
        int          r;
        logic [15:0] etype;
        logic [7:0]  proto;
        logic [31:0] head;
        r = $urandom_range(0, 9);
        if (r < 2)
            len = $urandom_range(1, 33);
        else if (r < 8)
            len = $urandom_range(34, 50);
        else
            len = $urandom_range(51, 90);
        if (well_formed) begin
            etype = ($urandom_range(0, 9) != 0) ? ETHERTYPE_IPV4
                    : ETHERTYPE_IPV4 ^ (16'd1 << $urandom_range(0, 15));
            proto = $urandom_range(0, 1) ? IP_PROTO_UDP : 8'($urandom);
            r = $urandom_range(0, 9);
            if (r < 5)
                head = SIG_WORD;
            else if (r < 7)
                head = SIG_WORD ^ (32'd1 << $urandom_range(0, 31));
            else
                head = $urandom;
        end else begin
            len   = $urandom_range(1, 90);
            etype = 16'($urandom);
            proto = 8'($urandom);
            head  = $urandom;
        end
        send_frame(len, etype, proto, pick_addr(), head, $urandom_range(0, 19) == 0);
    endtask

    // Hold the input off until every predicted result has come out
    task automatic drain();
        i_in_valid <= 1'b0;
        while (board.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int  pick;
        bit  hold_done;
        bit  drain_done;
        board = new();
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            addr_pool[i] = $urandom;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: table requests on an empty and a full table, frame length
        // boundaries, EtherType and protocol checks, priority of the blacklist
        send_table(REQ_REMOVE, 32'h0A00_0001);
        send_table(REQ_INSERT, 32'h0A00_0001);
        send_table(REQ_INSERT, 32'h0A00_0001);
        send_frame(1, ETHERTYPE_IPV4, IP_PROTO_UDP, 32'h0A00_0001, SIG_WORD, 1'b0);
        send_frame(13, ETHERTYPE_IPV4, IP_PROTO_UDP, 32'h0A00_0001, SIG_WORD, 1'b0);
        send_frame(14, ETHERTYPE_IPV4, IP_PROTO_UDP, 32'h0A00_0001, SIG_WORD, 1'b0);
        send_frame(33, ETHERTYPE_IPV4, IP_PROTO_UDP, 32'h0A00_0001, SIG_WORD, 1'b0);
        send_frame(34, ETHERTYPE_IPV4, PROTO_TCP, 32'h0A00_0001, 32'h0, 1'b0);
        send_frame(60, ETHERTYPE_IPV6, IP_PROTO_UDP, 32'hC0A8_0001, SIG_WORD, 1'b0);
        send_frame(45, ETHERTYPE_IPV4, IP_PROTO_UDP, 32'hC0A8_0001, SIG_WORD, 1'b0);
        send_frame(46, ETHERTYPE_IPV4, IP_PROTO_UDP, 32'hC0A8_0001, SIG_WORD, 1'b0);
        send_frame(46, ETHERTYPE_IPV4, PROTO_TCP, 32'hC0A8_0001, SIG_WORD, 1'b0);
        send_frame(80, ETHERTYPE_IPV4, IP_PROTO_UDP, 32'h0A00_0001, SIG_WORD, 1'b0);
        send_word(REQ_UNUSED, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        send_frame(50, ETHERTYPE_IPV4, IP_PROTO_UDP, 32'hC0A8_0002, SIG_WORD, 1'b1);
        send_table(REQ_REMOVE, 32'h0A00_0001);
        // one more insert than the table holds; then a present address
        for (int i = 0; i <= BLACKLIST_DEPTH; i++)
            send_table(REQ_INSERT, (i == 0) ? 32'h0 :
                                   (i == 1) ? 32'hFFFF_FFFF : 32'hAC10_0000 + i);
        send_table(REQ_INSERT, 32'hFFFF_FFFF);
        send_frame(40, ETHERTYPE_IPV4, IP_PROTO_UDP, 32'hFFFF_FFFF, 32'h0, 1'b0);
        send_frame(40, ETHERTYPE_IPV4, IP_PROTO_UDP, 32'h0, 32'h0, 1'b0);
        for (int i = 0; i <= BLACKLIST_DEPTH; i++)
            send_table(REQ_REMOVE, (i == 0) ? 32'h0 :
                                   (i == 1) ? 32'hFFFF_FFFF : 32'hAC10_0000 + i);
        drain();

        // Random: mostly well-formed IPv4 frames, blacklist churn, some noise
        words_sent = 0;
        hold_done  = 1'b0;
        drain_done = 1'b0;
        while (words_sent < RANDOM_WORDS) begin
            if (!hold_done && words_sent > 500) begin
                hold_request = 1'b1;
                hold_done    = 1'b1;
            end
            if (!drain_done && words_sent > 1000) begin
                drain();
                drain_done = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 18)
                send_table(REQ_INSERT, pick_addr());
            else if (pick < 30)
                send_table(REQ_REMOVE, pick_addr());
            else if (pick < 32)
                send_word(REQ_UNUSED, 8'($urandom), 1'($urandom_range(0, 1)), $urandom);
            else if (pick < 90)
                random_frame(1'b1);
            else
                random_frame(1'b0);
        end

        i_in_valid <= 1'b0;
        while (board.expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_results.size() == 0)
            $display("ipv4_blacklist_signature_filter_test: clean");
        else
            $display("ipv4_blacklist_signature_filter_test: errors");
        $finish;
    end

endmodule
